### rtl/gvf_pkg.sv
// Shared types, codes and constants of the GARCH state-space variance forecast block.
package gvf_pkg;

  localparam int DATA_W        = 32;
  localparam int Q_FRAC        = 16;
  localparam int KIND_W        = 3;
  localparam int FIELD_IDX_W   = 2;
  localparam int STATE_DIM_DEF = 4;
  localparam int IDX_MAX_W     = 4;

  typedef logic [IDX_MAX_W-1:0] gvf_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_MAT    = 3'd0,
    KIND_GAIN   = 3'd1,
    KIND_OFFSET = 3'd2,
    KIND_SEL    = 3'd3,
    KIND_INIT   = 3'd4,
    KIND_STEP   = 3'd5
  } gvf_kind_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ROW  = 3'd1,
    OP_OFS  = 3'd2,
    OP_DOT  = 3'd3,
    OP_GAM  = 3'd4,
    OP_UPD  = 3'd5,
    OP_EMIT = 3'd6
  } gvf_op_e;

  typedef struct packed {
    gvf_op_e  op;
    gvf_idx_t i;
    gvf_idx_t j;
    logic     first;
    logic     last;
  } gvf_cmd_t;

  typedef struct packed {
    logic out_free;
  } gvf_stat_t;

endpackage

### rtl/gvf_in_if.sv
// Input channel: valid/ready handshake with load or step payload.
interface gvf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [gvf_pkg::KIND_W-1:0]      kind;
  logic        [gvf_pkg::FIELD_IDX_W-1:0] row;
  logic        [gvf_pkg::FIELD_IDX_W-1:0] col;
  logic signed [gvf_pkg::DATA_W-1:0]      value;

  modport source (output valid, output kind, output row, output col, output value, input ready);
  modport sink (input valid, input kind, input row, input col, input value, output ready);
endinterface

### rtl/gvf_out_if.sv
// Output channel: valid/ready handshake with one forecast state element per transaction.
interface gvf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gvf_pkg::DATA_W-1:0]      sigma2;
  logic        [gvf_pkg::FIELD_IDX_W-1:0] elem_index;
  logic signed [gvf_pkg::DATA_W-1:0]      elem_value;
  logic                                   saturated;
  logic                                   last;

  modport source (output valid, output sigma2, output elem_index, output elem_value,
                  output saturated, output last, input ready);
  modport sink (input valid, input sigma2, input elem_index, input elem_value,
                input saturated, input last, output ready);
endinterface

### rtl/gvf_datapath.sv
// Datapath: coefficient stores, shared Q16.16 multiply-accumulate pipeline, output register.
module gvf_datapath #(
  parameter int STATE_DIM = gvf_pkg::STATE_DIM_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_acc_i,
  input  logic        [gvf_pkg::KIND_W-1:0]      in_kind_i,
  input  logic        [gvf_pkg::FIELD_IDX_W-1:0] in_row_i,
  input  logic        [gvf_pkg::FIELD_IDX_W-1:0] in_col_i,
  input  logic signed [gvf_pkg::DATA_W-1:0]      in_value_i,
  input  gvf_pkg::gvf_cmd_t                      cmd_i,
  output gvf_pkg::gvf_stat_t                     stat_o,
  gvf_out_if.source                              out_o
);

  localparam int IDX_W  = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
  localparam int MAT_D  = STATE_DIM * STATE_DIM;
  localparam int MAT_AW = (MAT_D > 1) ? $clog2(MAT_D) : 1;
  localparam int DW     = gvf_pkg::DATA_W;
  localparam int PW     = 2 * DW;
  localparam int QF     = gvf_pkg::Q_FRAC;

  localparam logic signed [DW-1:0] Q_ONE   = DW'(64'sd1 <<< QF);
  localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  // stores
  logic signed [DW-1:0] coef_mem [MAT_D];
  logic signed [DW-1:0] gain_q   [STATE_DIM];
  logic signed [DW-1:0] ofs_q    [STATE_DIM];
  logic signed [DW-1:0] sel_q    [STATE_DIM];
  logic signed [DW-1:0] scr_q    [STATE_DIM];
  logic signed [DW-1:0] state_q  [STATE_DIM];
  logic signed [DW-1:0] m2_q, sigma2_q, gamma_q, acc_q;
  logic                 sat_q;

  // load decode
  logic              row_ok, col_ok;
  logic              ld_mat, ld_gain, ld_ofs, ld_sel, ld_init, step_acc;
  logic [IDX_W-1:0]  ld_row;
  logic [MAT_AW-1:0] ld_addr;

  always_comb begin
    row_ok   = int'(in_row_i) < STATE_DIM;
    col_ok   = int'(in_col_i) < STATE_DIM;
    ld_mat   = 1'b0;
    ld_gain  = 1'b0;
    ld_ofs   = 1'b0;
    ld_sel   = 1'b0;
    ld_init  = 1'b0;
    step_acc = in_acc_i && (in_kind_i == gvf_pkg::KIND_STEP);
    if (in_acc_i && row_ok) begin
      case (in_kind_i)
        gvf_pkg::KIND_MAT:    ld_mat  = col_ok;
        gvf_pkg::KIND_GAIN:   ld_gain = 1'b1;
        gvf_pkg::KIND_OFFSET: ld_ofs  = 1'b1;
        gvf_pkg::KIND_SEL:    ld_sel  = 1'b1;
        gvf_pkg::KIND_INIT:   ld_init = 1'b1;
        default: ;
      endcase
    end
  end

  assign ld_row  = IDX_W'(in_row_i);
  assign ld_addr = MAT_AW'(int'(in_row_i) * STATE_DIM + int'(in_col_i));

  // issue stage: operand fetch
  logic [IDX_W-1:0]     ci, cj, sidx;
  logic [MAT_AW-1:0]    rd_addr;
  logic signed [DW-1:0] coef_rd_q, va_q, vb_q, add1_q, add2_q;
  logic signed [DW-1:0] va, vb, scr_rd, state_rd;
  gvf_pkg::gvf_cmd_t    t1_q, t2_q;

  assign ci       = cmd_i.i[IDX_W-1:0];
  assign cj       = cmd_i.j[IDX_W-1:0];
  assign sidx     = (cmd_i.op == gvf_pkg::OP_ROW) ? cj : ci;
  assign rd_addr  = MAT_AW'(int'(ci) * STATE_DIM + int'(cj));
  assign scr_rd   = scr_q[ci];
  assign state_rd = state_q[sidx];

  always_comb begin
    va = '0;
    vb = '0;
    case (cmd_i.op)
      gvf_pkg::OP_ROW: vb = state_rd;
      gvf_pkg::OP_OFS: begin
        va = ofs_q[ci];
        vb = Q_ONE;
      end
      gvf_pkg::OP_DOT: begin
        va = sel_q[ci];
        vb = scr_rd;
      end
      gvf_pkg::OP_GAM: begin
        va = m2_q;
        vb = sigma2_q;
      end
      gvf_pkg::OP_UPD: begin
        va = gain_q[ci];
        vb = gamma_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_mat) begin
      coef_mem[ld_addr] <= in_value_i;
    end
    coef_rd_q <= coef_mem[rd_addr];
  end

  // multiply stage
  logic signed [DW-1:0] mul_a;
  logic signed [PW-1:0] prod_q;

  assign mul_a = (t1_q.op == gvf_pkg::OP_ROW) ? coef_rd_q : va_q;

  always_ff @(posedge clk_i) begin
    va_q   <= va;
    vb_q   <= vb;
    add1_q <= scr_rd;
    add2_q <= add1_q;
    prod_q <= mul_a * vb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
    end else begin
      t1_q <= cmd_i;
      t2_q <= t1_q;
    end
  end

  // scale, saturate and accumulate stage
  logic                 ovf_p, ovf_s, active2;
  logic signed [DW-1:0] term, addend, res;
  logic signed [DW:0]   sum;
  logic [IDX_W-1:0]     i2;

  assign i2      = t2_q.i[IDX_W-1:0];
  assign ovf_p   = !((&prod_q[PW-1:DW+QF-1]) || (~|prod_q[PW-1:DW+QF-1]));
  assign term    = ovf_p ? (prod_q[PW-1] ? SAT_MIN : SAT_MAX) : prod_q[DW+QF-1:QF];
  assign addend  = t2_q.first ? ((t2_q.op == gvf_pkg::OP_UPD) ? add2_q : '0) : acc_q;
  assign sum     = {addend[DW-1], addend} + {term[DW-1], term};
  assign ovf_s   = sum[DW] ^ sum[DW-1];
  assign res     = ovf_s ? (sum[DW] ? SAT_MIN : SAT_MAX) : sum[DW-1:0];
  assign active2 = (t2_q.op == gvf_pkg::OP_ROW) || (t2_q.op == gvf_pkg::OP_OFS) ||
                   (t2_q.op == gvf_pkg::OP_DOT) || (t2_q.op == gvf_pkg::OP_GAM) ||
                   (t2_q.op == gvf_pkg::OP_UPD);

  always_ff @(posedge clk_i) begin
    if (ld_gain) gain_q[ld_row] <= in_value_i;
    if (ld_ofs)  ofs_q[ld_row]  <= in_value_i;
    if (ld_sel)  sel_q[ld_row]  <= in_value_i;
    if (step_acc) m2_q <= in_value_i;
    case (t2_q.op)
      gvf_pkg::OP_ROW: acc_q <= res;
      gvf_pkg::OP_OFS: scr_q[i2] <= res;
      gvf_pkg::OP_DOT: begin
        acc_q <= res;
        if (t2_q.last) sigma2_q <= res;
      end
      gvf_pkg::OP_GAM: gamma_q <= res;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{default: '0};
      sat_q   <= 1'b0;
    end else begin
      if (ld_init) begin
        state_q[ld_row] <= in_value_i;
      end else if (t2_q.op == gvf_pkg::OP_UPD) begin
        state_q[i2] <= res;
      end
      if (step_acc) begin
        sat_q <= 1'b0;
      end else if (active2 && (ovf_p || ovf_s)) begin
        sat_q <= 1'b1;
      end
    end
  end

  // output register
  logic                                   out_valid_q;
  logic signed [DW-1:0]                   o_sigma2_q, o_value_q;
  logic        [gvf_pkg::FIELD_IDX_W-1:0] o_index_q;
  logic                                   o_sat_q, o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == gvf_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == gvf_pkg::OP_EMIT) begin
      o_sigma2_q <= sigma2_q;
      o_index_q  <= cmd_i.i[gvf_pkg::FIELD_IDX_W-1:0];
      o_value_q  <= state_rd;
      o_sat_q    <= sat_q;
      o_last_q   <= cmd_i.last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sigma2     = o_sigma2_q;
  assign out_o.elem_index = o_index_q;
  assign out_o.elem_value = o_value_q;
  assign out_o.saturated  = o_sat_q;
  assign out_o.last       = o_last_q;

  assign stat_o.out_free  = !out_valid_q || out_o.ready;

endmodule

### rtl/gvf_ctrl.sv
// Controller: sequences the phases of one forecast step over the shared MAC pipeline.
module gvf_ctrl #(
  parameter int STATE_DIM = gvf_pkg::STATE_DIM_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_acc_i,
  input  logic [gvf_pkg::KIND_W-1:0]        in_kind_i,
  input  gvf_pkg::gvf_stat_t                stat_i,
  output logic                              in_ready_o,
  output gvf_pkg::gvf_cmd_t                 cmd_o
);

  localparam int IDX_W = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
  localparam int JW    = $clog2(STATE_DIM + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROW  = 3'd1;
  localparam logic [2:0] ST_DOT  = 3'd2;
  localparam logic [2:0] ST_GAM  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  // pipeline latency from issue to write-back
  localparam logic [1:0] DRAIN = 2'd2;

  logic [2:0]       state_q, state_d;
  logic [1:0]       drain_q, drain_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [JW-1:0]    j_q, j_d;
  logic             last_i, ofs_j;

  assign last_i = (i_q == IDX_W'(STATE_DIM - 1));
  assign ofs_j  = (j_q == JW'(STATE_DIM));

  always_comb begin
    state_d    = state_q;
    drain_d    = drain_q;
    i_d        = i_q;
    j_d        = j_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = gvf_pkg::OP_NONE;
    cmd_o.i    = gvf_pkg::gvf_idx_t'(i_q);
    if (drain_q != 2'd0) begin
      drain_d = drain_q - 2'd1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          in_ready_o = 1'b1;
          if (in_acc_i && (in_kind_i == gvf_pkg::KIND_STEP)) begin
            state_d = ST_ROW;
            i_d     = '0;
            j_d     = '0;
          end
        end
        ST_ROW: begin
          if (ofs_j) begin
            cmd_o.op   = gvf_pkg::OP_OFS;
            cmd_o.last = 1'b1;
            j_d        = '0;
            if (last_i) begin
              i_d     = '0;
              state_d = ST_DOT;
              drain_d = DRAIN;
            end else begin
              i_d = i_q + IDX_W'(1);
            end
          end else begin
            cmd_o.op    = gvf_pkg::OP_ROW;
            cmd_o.j     = gvf_pkg::gvf_idx_t'(j_q);
            cmd_o.first = (j_q == '0);
            j_d         = j_q + JW'(1);
          end
        end
        ST_DOT: begin
          cmd_o.op    = gvf_pkg::OP_DOT;
          cmd_o.first = (i_q == '0);
          cmd_o.last  = last_i;
          if (last_i) begin
            i_d     = '0;
            state_d = ST_GAM;
            drain_d = DRAIN;
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end
        ST_GAM: begin
          cmd_o.op    = gvf_pkg::OP_GAM;
          cmd_o.first = 1'b1;
          cmd_o.last  = 1'b1;
          state_d     = ST_UPD;
          drain_d     = DRAIN;
        end
        ST_UPD: begin
          cmd_o.op    = gvf_pkg::OP_UPD;
          cmd_o.first = 1'b1;
          cmd_o.last  = last_i;
          if (last_i) begin
            i_d     = '0;
            state_d = ST_EMIT;
            drain_d = DRAIN;
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end
        ST_EMIT: begin
          if (stat_i.out_free) begin
            cmd_o.op   = gvf_pkg::OP_EMIT;
            cmd_o.last = last_i;
            if (last_i) begin
              i_d     = '0;
              state_d = ST_IDLE;
            end else begin
              i_d = i_q + IDX_W'(1);
            end
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      drain_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  a_no_issue_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op != gvf_pkg::OP_NONE) |-> (drain_q == 2'd0))
    else $error("command issued while pipeline drains");

  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc_i && (in_kind_i == gvf_pkg::KIND_STEP)) |=> (state_q == ST_ROW))
    else $error("accepted step did not start matrix phase");

  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == gvf_pkg::OP_EMIT) |-> stat_i.out_free)
    else $error("emit while output register occupied");

  a_last_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_o.op == gvf_pkg::OP_EMIT) && cmd_o.last) |=> (state_q == ST_IDLE))
    else $error("controller not idle after final element");

endmodule

### rtl/garch_state_space_variance_forecast.sv
// Top level of the GARCH state-space variance forecast block.
// Load transactions (matrix entry, gain, offset, selector, initial state) are taken while
// idle and give no result; loads with an index not below STATE_DIM are dropped.
// A step transaction runs F = A*E + offset, sigma2 = selector.F and E = F + gain*(m2*sigma2)
// through one shared Q16.16 multiply-accumulate pipeline of three stages that takes one
// product per cycle: D*(D+1) terms for the matrix rows and offsets, D for sigma2, one for
// the gamma product and D for the update, with a drain between phases. The D results
// follow one per cycle while the sink is ready; new transactions are taken only between
// steps, though the last result may still wait in the output register. The saturation
// flag covers every product and sum of the step. Matrix, gain, offset and selector
// stores are undefined until loaded; the state vector resets to zero.
module garch_state_space_variance_forecast #(
  parameter int STATE_DIM = gvf_pkg::STATE_DIM_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  gvf_in_if.sink  in_i,
  gvf_out_if.source out_o
);

  logic               in_acc, in_ready;
  gvf_pkg::gvf_cmd_t  cmd;
  gvf_pkg::gvf_stat_t stat;

  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid && in_ready;

  gvf_ctrl #(
    .STATE_DIM (STATE_DIM)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_acc),
    .in_kind_i  (in_i.kind),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  gvf_datapath #(
    .STATE_DIM (STATE_DIM)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_acc),
    .in_kind_i  (in_i.kind),
    .in_row_i   (in_i.row),
    .in_col_i   (in_i.col),
    .in_value_i (in_i.value),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_o      (out_o)
  );

endmodule
